[rtl/playfair_digraph_cipher_macros.svh]
// Assertion macros for the Playfair cipher block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define PFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pfc_pkg.sv]
// Shared types, constants and small functions of the Playfair cipher block.
// Used by pfc_ctrl, pfc_dpath and playfair_digraph_cipher; no dependencies.
package pfc_pkg;

    localparam int SQUARE_SIZE = 25;
    localparam int ALPHA_SIZE  = 26;

    localparam logic [4:0] IDX_I    = 5'd8;
    localparam logic [4:0] IDX_J    = 5'd9;
    localparam logic [4:0] IDX_X    = 5'd23;
    localparam logic [4:0] IDX_LAST = 5'd25;
    localparam logic [6:0] ASCII_A  = 7'd65;

    typedef enum logic [2:0] {
        ACT_KEY_START = 3'd0,
        ACT_KEY_CHAR  = 3'd1,
        ACT_KEY_END   = 3'd2,
        ACT_TEXT_CHAR = 3'd3,
        ACT_TEXT_END  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SLOT,
        ST_SQUARE,
        ST_EMIT_A,
        ST_EMIT_B
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_key;
        logic place_key;
        logic fill_start;
        logic fill_step;
        logic hold_text;
        logic pair_text;
        logic pair_tail;
        logic drop_held;
        logic slot_rd;
        logic square_rd;
        logic emit_second;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mode;
        logic key_ready;
        logic held_valid;
        logic sym_ok;
        logic fill_done;
    } status_t;

    // Map ASCII to {is_letter, letter index}, J folded into I
    function automatic logic [5:0] letter_decode(input logic [7:0] sym);
        logic [7:0] off;
        logic [4:0] idx;
        logic       ok;
        begin
            off = 8'd0;
            ok  = 1'b0;
            if (sym >= 8'h41 && sym <= 8'h5A)
            begin
                off = sym - 8'h41;
                ok  = 1'b1;
            end
            else if (sym >= 8'h61 && sym <= 8'h7A)
            begin
                off = sym - 8'h61;
                ok  = 1'b1;
            end
            idx = off[4:0];
            if (idx == IDX_J)
                idx = IDX_I;
            return {ok, idx};
        end
    endfunction

    // Split a square position 0..24 into {row, col}
    function automatic logic [5:0] pos_split(input logic [4:0] pos);
        logic [2:0] row;
        logic [4:0] base;
        logic [4:0] col;
        begin
            if (pos >= 5'd20)
                row = 3'd4;
            else if (pos >= 5'd15)
                row = 3'd3;
            else if (pos >= 5'd10)
                row = 3'd2;
            else if (pos >= 5'd5)
                row = 3'd1;
            else
                row = 3'd0;
            base = {row, 2'b00} + {2'b00, row};
            col  = pos - base;
            return {row, col[2:0]};
        end
    endfunction

    // Rebuild a square position from row and column
    function automatic logic [4:0] pos_join(input logic [2:0] row, input logic [2:0] col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

    // Step one place around a row or column of five, back when back is set
    function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic back);
        logic [2:0] r;
        begin
            if (back)
                r = (v == 3'd0) ? 3'd4 : v - 3'd1;
            else
                r = (v == 3'd4) ? 3'd0 : v + 3'd1;
            return r;
        end
    endfunction

endpackage

[rtl/pfc_ctrl.sv]
// Controller state machine of the Playfair cipher block.
// Depends on pfc_pkg; drives pfc_dpath through cmd_t, reads status_t.
module pfc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [2:0]        action,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_tlast,
    input  pfc_pkg::status_t  status,
    output pfc_pkg::cmd_t     cmd
);
    import pfc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   go_fill;
    logic   go_pair;

    assign accept = s_tvalid && (state_reg == ST_IDLE);

    // Decode which accepted items start multi-cycle work
    always_comb
    begin
        go_fill = 1'b0;
        go_pair = 1'b0;
        unique case (action)
            ACT_KEY_END:
                go_fill = !status.key_ready;
            ACT_TEXT_CHAR:
                go_pair = status.key_ready && status.sym_ok && status.held_valid;
            ACT_TEXT_END:
                go_pair = status.key_ready && status.held_valid && !status.mode;
            default:
            begin
                go_fill = 1'b0;
                go_pair = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && go_fill)
                    state_next = ST_FILL;
                else if (accept && go_pair)
                    state_next = ST_SLOT;
            end
            ST_FILL:
                if (status.fill_done)
                    state_next = ST_IDLE;
            ST_SLOT:
                state_next = ST_SQUARE;
            ST_SQUARE:
                state_next = ST_EMIT_A;
            ST_EMIT_A:
                if (m_tready)
                    state_next = ST_EMIT_B;
            ST_EMIT_B:
                if (m_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        m_tlast  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept)
                begin
                    unique case (action)
                        ACT_KEY_START:
                            cmd.clear_key = 1'b1;
                        ACT_KEY_CHAR:
                            cmd.place_key = !status.key_ready;
                        ACT_KEY_END:
                            cmd.fill_start = go_fill;
                        ACT_TEXT_CHAR:
                        begin
                            cmd.hold_text = status.key_ready && status.sym_ok
                                            && !status.held_valid;
                            cmd.pair_text = go_pair;
                        end
                        ACT_TEXT_END:
                        begin
                            cmd.pair_tail = go_pair;
                            cmd.drop_held = status.key_ready && status.held_valid
                                            && status.mode;
                        end
                        default:
                            cmd.clear_key = 1'b0;
                    endcase
                end
            end
            ST_FILL:
                cmd.fill_step = 1'b1;
            ST_SLOT:
                cmd.slot_rd = 1'b1;
            ST_SQUARE:
                cmd.square_rd = 1'b1;
            ST_EMIT_A:
                m_tvalid = 1'b1;
            ST_EMIT_B:
            begin
                m_tvalid        = 1'b1;
                m_tlast         = 1'b1;
                cmd.emit_second = 1'b1;
            end
            default:
                s_tready = 1'b0;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/pfc_dpath.sv]
// Datapath of the Playfair cipher block: key square, letter slots, pair lookup.
// Depends on pfc_pkg; commanded by pfc_ctrl through cmd_t.
module pfc_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic [7:0]        symbol,
    input  pfc_pkg::cmd_t     cmd,
    output pfc_pkg::status_t  status,
    output logic [6:0]        letter
);
    import pfc_pkg::*;

    // Key square and inverse map
    logic [4:0] square_mem [SQUARE_SIZE];
    logic [4:0] slot_mem   [ALPHA_SIZE];

    logic                  mode_reg;
    logic [ALPHA_SIZE-1:0] used_reg, used_next;
    logic [4:0]            fill_count_reg, fill_count_next;
    logic                  key_ready_reg, key_ready_next;
    logic [4:0]            held_letter_reg, held_letter_next;
    logic                  held_valid_reg, held_valid_next;
    logic [4:0]            fill_idx_reg, fill_idx_next;

    logic [4:0] a_reg, b_reg;
    logic [4:0] pa_reg, pb_reg;
    logic [4:0] qa_let_reg, qb_let_reg;

    logic [5:0] sym_dec;
    logic       sym_ok;
    logic [4:0] sym_idx;
    logic       doubled;
    logic       place_en;
    logic [4:0] place_idx;
    logic       do_place;
    logic [5:0] rc_a, rc_b;
    logic [2:0] ra, ca, rb, cb;
    logic [4:0] qa, qb;
    logic [4:0] out_idx;

    assign sym_dec = letter_decode(symbol);
    assign sym_ok  = sym_dec[5];
    assign sym_idx = sym_dec[4:0];
    assign doubled = !mode_reg && (sym_idx == held_letter_reg);

    // Pick the letter to place: key symbol or sweep candidate
    assign place_en  = (cmd.place_key && sym_ok) || (cmd.fill_step && fill_idx_reg != IDX_J);
    assign place_idx = cmd.fill_step ? fill_idx_reg : sym_idx;
    assign do_place  = place_en && !used_reg[place_idx]
                       && (fill_count_reg < 5'(SQUARE_SIZE));

    // Key and text bookkeeping
    always_comb
    begin
        used_next        = used_reg;
        fill_count_next  = fill_count_reg;
        key_ready_next   = key_ready_reg;
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        fill_idx_next    = fill_idx_reg;
        if (cmd.clear_key)
        begin
            used_next       = '0;
            fill_count_next = 5'd0;
            key_ready_next  = 1'b0;
            held_valid_next = 1'b0;
        end
        if (do_place)
        begin
            used_next[place_idx] = 1'b1;
            fill_count_next      = fill_count_reg + 5'd1;
        end
        if (cmd.fill_start)
        begin
            fill_idx_next   = 5'd0;
            held_valid_next = 1'b0;
        end
        if (cmd.fill_step)
        begin
            fill_idx_next = fill_idx_reg + 5'd1;
            if (fill_idx_reg == IDX_LAST)
                key_ready_next = 1'b1;
        end
        if (cmd.hold_text)
        begin
            held_letter_next = sym_idx;
            held_valid_next  = 1'b1;
        end
        if (cmd.pair_text)
            held_valid_next = doubled;
        if (cmd.pair_tail || cmd.drop_held)
            held_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            used_reg        <= '0;
            fill_count_reg  <= 5'd0;
            key_ready_reg   <= 1'b0;
            held_letter_reg <= 5'd0;
            held_valid_reg  <= 1'b0;
            fill_idx_reg    <= 5'd0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_wdata;
            used_reg        <= used_next;
            fill_count_reg  <= fill_count_next;
            key_ready_reg   <= key_ready_next;
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
            fill_idx_reg    <= fill_idx_next;
        end
    end

    // Latch the pair of letter indexes; a doubled letter pairs with X
    always_ff @(posedge clk)
    begin
        if (cmd.pair_text)
        begin
            a_reg <= held_letter_reg;
            b_reg <= doubled ? IDX_X : sym_idx;
        end
        else if (cmd.pair_tail)
        begin
            a_reg <= held_letter_reg;
            b_reg <= IDX_X;
        end
    end

    // Square and slot memories: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (do_place)
        begin
            square_mem[fill_count_reg] <= place_idx;
            slot_mem[place_idx]        <= fill_count_reg;
        end
        if (cmd.slot_rd)
        begin
            pa_reg <= slot_mem[a_reg];
            pb_reg <= slot_mem[b_reg];
        end
        if (cmd.square_rd)
        begin
            qa_let_reg <= square_mem[qa];
            qb_let_reg <= square_mem[qb];
        end
    end

    // Row, column and rectangle rules
    assign rc_a = pos_split(pa_reg);
    assign rc_b = pos_split(pb_reg);
    assign ra   = rc_a[5:3];
    assign ca   = rc_a[2:0];
    assign rb   = rc_b[5:3];
    assign cb   = rc_b[2:0];

    always_comb
    begin
        priority if (ra == rb)
        begin
            qa = pos_join(ra, wrap_step(ca, mode_reg));
            qb = pos_join(rb, wrap_step(cb, mode_reg));
        end
        else if (ca == cb)
        begin
            qa = pos_join(wrap_step(ra, mode_reg), ca);
            qb = pos_join(wrap_step(rb, mode_reg), cb);
        end
        else
        begin
            qa = pos_join(ra, cb);
            qb = pos_join(rb, ca);
        end
    end

    // Present the selected letter of the pair as ASCII
    assign out_idx = cmd.emit_second ? qb_let_reg : qa_let_reg;
    assign letter  = ASCII_A + {2'b00, out_idx};

    assign status.mode       = mode_reg;
    assign status.key_ready  = key_ready_reg;
    assign status.held_valid = held_valid_reg;
    assign status.sym_ok     = sym_ok;
    assign status.fill_done  = (fill_idx_reg == IDX_LAST);

endmodule

[rtl/playfair_digraph_cipher.sv]
// Top level of the Playfair cipher block: controller plus datapath.
// Depends on pfc_pkg, pfc_ctrl, pfc_dpath and playfair_digraph_cipher_macros.svh.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  s_tuser = action, s_tdata = symbol
//  m_*       out        m_tvalid / m_tready  m_tdata = letter, m_tlast = last
//  cfg_*     in         cfg_we               cfg_wdata = mode
//
// Key char, key start and items that give no result are handled on acceptance.
// Key end is accepted, then a sweep over all 26 letters fills the square.
// A pair steps through accept, slot read and square read, then offers its two
// letters in turn; s_tready is low until both letters are taken.
// m_tready low holds the current letter; reset leaves no key and mode encrypt.
`include "playfair_digraph_cipher_macros.svh"

module playfair_digraph_cipher (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic [2:0] s_tuser,   // [2:0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] letter, [7] zero
    output logic       m_tlast,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);
    import pfc_pkg::*;

    cmd_t       cmd;
    status_t    status;
    logic [6:0] letter;

    pfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    pfc_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .symbol    (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .letter    (letter)
    );

    assign m_tdata = {1'b0, letter};

    // Input is never taken while a letter is on offer
    `PFC_ASSERT_NOW(a_no_accept_on_output, m_tvalid, !s_tready, "input ready while output valid")
    // The first letter of a pair is always followed by the second
    `PFC_ASSERT_NEXT(a_pair_follows, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast, "second letter missing")
    // Emitted letters are upper case
    `PFC_ASSERT_NOW(a_letter_range, m_tvalid, (m_tdata >= 8'd65) && (m_tdata <= 8'd90), "letter out of range")
    // A pair only starts from a completed key square
    `PFC_ASSERT_NOW(a_pair_needs_key, cmd.pair_text || cmd.pair_tail, status.key_ready, "pair without key")

endmodule

[tb/playfair_digraph_cipher_tb.sv]
// Testbench for playfair_digraph_cipher: directed table, then random key and text phases.
// Predicts letters by its own square model or the table; needs pfc_pkg and the block RTL.
`timescale 1ns / 1ps

module playfair_digraph_cipher_tb;
    import pfc_pkg::*;

    // Action codes the block does not define
    localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI  = 3'd7;
    localparam logic       MODE_ENCRYPT  = 1'b0;
    localparam logic       MODE_DECRYPT  = 1'b1;
    localparam int         MAX_GAP       = 13;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         TARGET_ITEMS  = 950;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         DIR_ROWS      = 33;

    typedef struct packed {
        logic [6:0] letter;
        logic       last;
    } letter_exp_t;

    typedef struct packed {
        logic [2:0] act;
        logic [7:0] sym;
        logic       known;
        logic [1:0] n;
        logic [6:0] e0;
        logic [6:0] e1;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [2:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       cfg_we;
    logic       cfg_wdata;

    // Predictor state
    logic [4:0]  sq_letter [SQUARE_SIZE];
    logic [4:0]  slot_of [ALPHA_SIZE];
    logic [25:0] used;
    int          filled;
    bit          ready;
    logic [4:0]  held;
    bit          held_v;
    logic        mode_r;

    letter_exp_t pending_letters [$];
    dir_row_t    dir_rows [DIR_ROWS];
    int          errors = 0;
    int          sent;
    int          cycle_count = 0;
    bit          rush;

    playfair_digraph_cipher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Map a symbol to a letter index with J folded into I, or -1
    function automatic int sym_to_index(input logic [7:0] sym);
        int idx;
        if (sym >= "A" && sym <= "Z")
            idx = int'(sym) - int'("A");
        else if (sym >= "a" && sym <= "z")
            idx = int'(sym) - int'("a");
        else
            return -1;
        if (idx == int'(IDX_J))
            idx = int'(IDX_I);
        return idx;
    endfunction

    function automatic void add_to_square(input int idx);
        if (filled >= SQUARE_SIZE || used[idx])
            return;
        sq_letter[filled] = 5'(idx);
        slot_of[idx]      = 5'(filled);
        used[idx]         = 1'b1;
        filled++;
    endfunction

    // Code one pair by the row, column and rectangle rules
    function automatic void code_pair(input int a, input int b,
                                      output logic [6:0] l0, output logic [6:0] l1);
        int pa, pb, ra, ca, rb, cb, d, qa, qb;
        pa = int'(slot_of[a]);
        pb = int'(slot_of[b]);
        ra = pa / 5;
        ca = pa % 5;
        rb = pb / 5;
        cb = pb % 5;
        d  = (mode_r == MODE_DECRYPT) ? 4 : 1;
        if (ra == rb)
        begin
            qa = ra * 5 + (ca + d) % 5;
            qb = rb * 5 + (cb + d) % 5;
        end
        else if (ca == cb)
        begin
            qa = ((ra + d) % 5) * 5 + ca;
            qb = ((rb + d) % 5) * 5 + cb;
        end
        else
        begin
            qa = ra * 5 + cb;
            qb = rb * 5 + ca;
        end
        l0 = ASCII_A + {2'b00, sq_letter[qa]};
        l1 = ASCII_A + {2'b00, sq_letter[qb]};
    endfunction

    // Advance the predictor by one item; return the number of letters it yields
    function automatic int cipher_step(input logic [2:0] act, input logic [7:0] sym,
                                       output logic [6:0] l0, output logic [6:0] l1);
        int idx;
        int n;
        n  = 0;
        l0 = '0;
        l1 = '0;
        idx = sym_to_index(sym);
        case (act)
            ACT_KEY_START:
            begin
                used   = '0;
                filled = 0;
                ready  = 1'b0;
                held_v = 1'b0;
            end
            ACT_KEY_CHAR:
            begin
                if (!ready && idx >= 0)
                    add_to_square(idx);
            end
            ACT_KEY_END:
            begin
                if (!ready)
                begin
                    for (int i = 0; i < ALPHA_SIZE; i++)
                        if (i != int'(IDX_J))
                            add_to_square(i);
                    ready  = 1'b1;
                    held_v = 1'b0;
                end
            end
            ACT_TEXT_CHAR:
            begin
                if (ready && idx >= 0)
                begin
                    if (!held_v)
                    begin
                        held   = 5'(idx);
                        held_v = 1'b1;
                    end
                    else if (mode_r == MODE_ENCRYPT && idx == int'(held))
                    begin
                        // doubled letter: pair with X, keep the new one held
                        code_pair(int'(held), int'(IDX_X), l0, l1);
                        n = 2;
                    end
                    else
                    begin
                        held_v = 1'b0;
                        code_pair(int'(held), idx, l0, l1);
                        n = 2;
                    end
                end
            end
            ACT_TEXT_END:
            begin
                if (ready && held_v)
                begin
                    held_v = 1'b0;
                    if (mode_r == MODE_ENCRYPT)
                    begin
                        code_pair(int'(held), int'(IDX_X), l0, l1);
                        n = 2;
                    end
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    // Append both letters of a pair to the expected queue
    function automatic void push_pair(input logic [6:0] l0, input logic [6:0] l1);
        letter_exp_t lead_item;
        letter_exp_t tail_item;
        lead_item.letter = l0;
        lead_item.last   = 1'b0;
        tail_item.letter = l1;
        tail_item.last   = 1'b1;
        pending_letters  = {pending_letters, lead_item, tail_item};
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(1, 0) ? "a" : "A";
        return base + 8'($urandom_range(25, 0));
    endfunction

    // Drive one item after a random gap and hold it until accepted
    task automatic send_item(input logic [2:0] act, input logic [7:0] sym);
        int gap;
        gap = rush ? 0 : $urandom_range(MAX_GAP, 0);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= sym;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    task automatic feed(input logic [2:0] act, input logic [7:0] sym);
        logic [6:0] l0, l1;
        send_item(act, sym);
        if (cipher_step(act, sym, l0, l1) == 2)
            push_pair(l0, l1);
    endtask

    // Drop valid, drain all expected letters, then let the block go idle
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_letters.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge clk);
        cfg_we    <= 1'b0;
        mode_r = m;
    endtask

    // One random phase: optional new key, then mostly letters with some noise
    task automatic run_phase(input bit rekey, input bit close_key, input int n_text);
        logic [7:0] prev;
        int         r;
        if (rekey)
        begin
            if ($urandom_range(3, 0) != 0)
                feed(ACT_KEY_START, 8'($urandom_range(255, 0)));
            repeat ($urandom_range(14, 0))
            begin
                if ($urandom_range(4, 0) == 0)
                    feed(ACT_KEY_CHAR, 8'($urandom_range(255, 0)));
                else
                    feed(ACT_KEY_CHAR, rand_letter());
            end
            if (close_key)
                feed(ACT_KEY_END, 8'($urandom_range(255, 0)));
        end
        prev = rand_letter();
        repeat (n_text)
        begin
            r = $urandom_range(99, 0);
            if (r < 3)
                feed(3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO)), 8'($urandom_range(255, 0)));
            else if (r < 5)
                feed(ACT_KEY_CHAR, rand_letter());
            else if (r < 10)
                feed(ACT_TEXT_END, 8'($urandom_range(255, 0)));
            else if (r < 16)
                feed(ACT_TEXT_CHAR, 8'($urandom_range(255, 0)));
            else if (r < 32)
                // repeat the previous letter, case at random
                feed(ACT_TEXT_CHAR, $urandom_range(1, 0) ? (prev ^ 8'h20) : prev);
            else
            begin
                prev = rand_letter();
                feed(ACT_TEXT_CHAR, prev);
            end
        end
        if ($urandom_range(1, 0))
            feed(ACT_TEXT_END, 8'($urandom_range(255, 0)));
    endtask

    // Compare each accepted letter with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_letters.size() == 0)
            begin
                $display("%0t: unexpected letter, expected none, got %h last %b",
                         $time, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                if (m_tdata !== {1'b0, pending_letters[0].letter})
                begin
                    $display("%0t: letter mismatch, expected %h, got %h",
                             $time, {1'b0, pending_letters[0].letter}, m_tdata);
                    errors++;
                end
                if (m_tlast !== pending_letters[0].last)
                begin
                    $display("%0t: last mismatch, expected %b, got %b",
                             $time, pending_letters[0].last, m_tlast);
                    errors++;
                end
                void'(pending_letters.pop_front());
            end
        end
    end

    // Stall the output side for a random gap before each letter; no stall while rushing
    initial
    begin
        int w;
        wait (rst_n === 1'b1);
        forever
        begin
            w = rush ? 0 : $urandom_range(MAX_GAP, 0);
            repeat (w)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [6:0] l0, l1;
        int         n;
        int         ph;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        m_tready    = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 1'b0;
        sent        = 0;
        rush        = 1'b0;
        mode_r      = MODE_ENCRYPT;
        used        = '0;
        filled      = 0;
        ready       = 1'b0;
        held        = '0;
        held_v      = 1'b0;
        for (int i = 0; i < SQUARE_SIZE; i++)
            sq_letter[i] = '0;
        for (int i = 0; i < ALPHA_SIZE; i++)
            slot_of[i] = '0;

        // Square after a bare key end is the alphabet without J, row by row
        dir_rows = '{
            '{ACT_TEXT_CHAR, "A",   1'b1, 2'd0, 7'd0,  7'd0 },  // text before key
            '{ACT_TEXT_END,  8'h00, 1'b1, 2'd0, 7'd0,  7'd0 },
            '{ACT_KEY_END,   8'h00, 1'b1, 2'd0, 7'd0,  7'd0 },  // no start key
            '{ACT_KEY_CHAR,  "Q",   1'b1, 2'd0, 7'd0,  7'd0 },  // key char after end
            '{ACT_KEY_END,   8'h00, 1'b1, 2'd0, 7'd0,  7'd0 },  // key end when ready
            '{ACT_TEXT_CHAR, "A",   1'b1, 2'd0, 7'd0,  7'd0 },
            '{ACT_TEXT_CHAR, "B",   1'b1, 2'd2, 7'd66, 7'd67},  // same row
            '{ACT_TEXT_CHAR, "a",   1'b1, 2'd0, 7'd0,  7'd0 },
            '{ACT_TEXT_CHAR, "f",   1'b1, 2'd2, 7'd70, 7'd76},  // same column
            '{ACT_TEXT_CHAR, "A",   1'b1, 2'd0, 7'd0,  7'd0 },
            '{ACT_TEXT_CHAR, "G",   1'b1, 2'd2, 7'd66, 7'd70},  // rectangle
            '{ACT_TEXT_CHAR, "L",   1'b1, 2'd0, 7'd0,  7'd0 },
            '{ACT_TEXT_CHAR, "L",   1'b1, 2'd2, 7'd78, 7'd86},  // doubled letter
            '{ACT_TEXT_END,  8'h00, 1'b1, 2'd2, 7'd78, 7'd86},  // odd tail padded
            '{ACT_TEXT_CHAR, "J",   1'b1, 2'd0, 7'd0,  7'd0 },  // J read as I
            '{ACT_TEXT_CHAR, "K",   1'b1, 2'd2, 7'd75, 7'd70},
            '{ACT_TEXT_CHAR, "X",   1'b1, 2'd0, 7'd0,  7'd0 },
            '{ACT_TEXT_CHAR, "X",   1'b1, 2'd2, 7'd89, 7'd89},  // doubled X
            '{ACT_TEXT_CHAR, 8'hFF, 1'b1, 2'd0, 7'd0,  7'd0 },  // non-letter
            '{ACT_TEXT_CHAR, "z",   1'b1, 2'd2, 7'd89, 7'd86},
            '{ACT_TEXT_CHAR, "M",   1'b1, 2'd0, 7'd0,  7'd0 },
            '{ACT_TEXT_END,  8'h00, 1'b1, 2'd2, 7'd78, 7'd87},
            '{ACT_SPARE_HI,  "A",   1'b1, 2'd0, 7'd0,  7'd0 },  // unused action
            '{ACT_KEY_START, 8'hFF, 1'b0, 2'd0, 7'd0,  7'd0 },
            '{ACT_KEY_CHAR,  "z",   1'b0, 2'd0, 7'd0,  7'd0 },
            '{ACT_KEY_CHAR,  "J",   1'b0, 2'd0, 7'd0,  7'd0 },
            '{ACT_KEY_CHAR,  "!",   1'b0, 2'd0, 7'd0,  7'd0 },
            '{ACT_KEY_CHAR,  "z",   1'b0, 2'd0, 7'd0,  7'd0 },  // repeated key letter
            '{ACT_KEY_END,   8'h00, 1'b0, 2'd0, 7'd0,  7'd0 },
            '{ACT_TEXT_CHAR, "q",   1'b0, 2'd0, 7'd0,  7'd0 },
            '{ACT_TEXT_CHAR, "q",   1'b0, 2'd0, 7'd0,  7'd0 },
            '{ACT_TEXT_CHAR, "s",   1'b0, 2'd0, 7'd0,  7'd0 },
            '{ACT_TEXT_END,  8'h00, 1'b0, 2'd0, 7'd0,  7'd0 }
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_mode(MODE_ENCRYPT);

        // Walk the directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_item(dir_rows[i].act, dir_rows[i].sym);
            n = cipher_step(dir_rows[i].act, dir_rows[i].sym, l0, l1);
            if (dir_rows[i].known)
            begin
                if (dir_rows[i].n == 2'd2)
                    push_pair(dir_rows[i].e0, dir_rows[i].e1);
            end
            else if (n == 2)
                push_pair(l0, l1);
        end
        settle();

        // Random phases; mode changes only while idle, held letters may carry over
        ph = 0;
        while (sent < TARGET_ITEMS)
        begin
            if (ph == 0)
                set_mode(MODE_DECRYPT);
            else if (ph == 1)
                set_mode(MODE_ENCRYPT);
            else
                set_mode(logic'($urandom_range(1, 0)));
            rush = (ph % 4 == 3);
            run_phase(ph == 0 || $urandom_range(1, 0) == 1,
                      $urandom_range(9, 0) != 0,
                      $urandom_range(60, 20));
            settle();
            ph++;
        end
        rush = 1'b0;

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
